FILE: hdl/frp_pkg.sv
// ----------------------------------------------------------------------------
// frp_pkg: shared constants for the frame rate pacer
// Tick and rate widths, event codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package frp_pkg;

    localparam int TICK_WIDTH     = 32;
    localparam int RATE_FRAC_BITS = 16;

    // rates are unsigned Q12.F
    localparam int RATE_W = 12 + RATE_FRAC_BITS;

    localparam int OP_W      = 2;
    localparam int PERIOD_W  = 16;
    localparam int TARGET_W  = 12;
    localparam int ACTIVE_W  = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_BEGIN       = 2'd0;
    localparam op_t OP_FRAME_START = 2'd1;
    localparam op_t OP_FRAME_END   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_PERIOD = 1'd1;

endpackage

`default_nettype wire

FILE: hdl/frp_event_if.sv
// ----------------------------------------------------------------------------
// frp_event_if: event request channel
// Valid/ready channel carrying an event code and its tick stamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface frp_event_if;

    logic                            valid;
    logic                            ready;
    logic [frp_pkg::OP_W-1:0]        operation;
    logic [frp_pkg::TICK_WIDTH-1:0]  tick;

    modport source (output valid, operation, tick, input ready);
    modport sink   (input valid, operation, tick, output ready);

endinterface

`default_nettype wire

FILE: hdl/frp_result_if.sv
// ----------------------------------------------------------------------------
// frp_result_if: result channel
// Valid/ready channel carrying one pacer result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface frp_result_if;

    logic                           valid;
    logic                           ready;
    logic [frp_pkg::PERIOD_W-1:0]   frame_delta;
    logic [frp_pkg::PERIOD_W-1:0]   delay_ticks;
    logic                           config_error;

    modport source (output valid, frame_delta, delay_ticks, config_error, input ready);
    modport sink   (input valid, frame_delta, delay_ticks, config_error, output ready);

endinterface

`default_nettype wire

FILE: hdl/frp_cfg_if.sv
// ----------------------------------------------------------------------------
// frp_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface frp_cfg_if;

    logic                            valid;
    logic                            ready;
    logic [frp_pkg::CFG_IDX_W-1:0]   index;
    logic [frp_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);

endinterface

`default_nettype wire

FILE: hdl/frame_rate_pacer.sv
// ----------------------------------------------------------------------------
// frame_rate_pacer: frame pacing from tick-stamped events
// Begin / frame start / frame end events; one result per request.
// ----------------------------------------------------------------------------
// Takes one request at a time. The reciprocal divisions (frame period on a
// begin, measured rate on a frame start) run through a single restoring
// divider that retires one quotient bit per cycle (RATE_FRAC_BITS+13 bits,
// 29 at the default). The divide by five for the smoothing is a reciprocal
// multiply in the ST_SCALE state. A begin runs one division; a frame start
// runs the measured rate division, then the scaled smoothing, and skips
// the division when the tick delta is zero; a frame end needs no division.
// A finished result sits in an output register, so a new request is taken
// while it waits.
`default_nettype none

module frame_rate_pacer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    frp_event_if.sink        events,
    frp_result_if.source     results,
    frp_cfg_if.sink          cfg
);

    localparam int TW     = frp_pkg::TICK_WIDTH;
    localparam int FB     = frp_pkg::RATE_FRAC_BITS;
    localparam int RW     = frp_pkg::RATE_W;
    localparam int PW     = frp_pkg::PERIOD_W;
    localparam int AW     = frp_pkg::ACTIVE_W;
    localparam int DIV_W  = RW + 1;
    localparam int DVS_W  = TW;
    localparam int CNT_W  = $clog2(DIV_W);

    // x / 5 == (x * ceil(2^(DIV_W+2) / 5)) >> (DIV_W+2) for any DIV_W-bit x
    localparam int               RECIP_SHIFT = DIV_W + 2;
    localparam logic [DIV_W-1:0] RECIP_5     =
        DIV_W'(((64'd1 << RECIP_SHIFT) + 64'd4) / 64'd5);

    localparam logic [DIV_W-1:0] RATE_1000   = DIV_W'(1000) << FB;
    localparam logic [DIV_W-1:0] DIVIDEND_1K = DIV_W'(1000);
    localparam logic [RW-1:0]    RATE_MAX    = RW'(2000) << FB;
    localparam int               DEAD_BAND   = ((1 << FB) + 9999) / 10000;
    localparam logic [AW-1:0]    UNLIMITED   = AW'(2000);
    localparam logic [PW-1:0]    PERIOD_MAX  = {PW{1'b1}};

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_POST  = 3'd2;
    localparam logic [2:0] ST_END   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;
    localparam logic [2:0] ST_SCALE = 3'd5;

    localparam logic [1:0] PH_BEGIN  = 2'd0;
    localparam logic [1:0] PH_MEAS   = 2'd1;
    localparam logic [1:0] PH_SMOOTH = 2'd2;

    // control
    logic [2:0]          state_reg, state_next;
    logic [1:0]          phase_reg, phase_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;

    // configuration and pacer state
    logic [frp_pkg::TARGET_W-1:0] target_rate_reg, target_rate_next;
    logic [PW-1:0]       fallback_reg, fallback_next;
    logic [TW-1:0]       last_tick_reg, last_tick_next;
    logic [PW-1:0]       period_reg, period_next;
    logic [RW-1:0]       smooth_reg, smooth_next;
    logic [AW-1:0]       active_reg, active_next;

    // request and divider payload
    frp_pkg::op_t        op_reg, op_next;
    logic [TW-1:0]       tick_reg, tick_next;
    logic [TW-1:0]       delta_reg, delta_next;
    logic [DVS_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [DVS_W-1:0]    dvs_reg, dvs_next;
    logic [PW-1:0]       res_delta_reg, res_delta_next;
    logic [PW-1:0]       res_delay_reg, res_delay_next;
    logic                res_err_reg, res_err_next;
    logic [PW-1:0]       out_delta_reg, out_delta_next;
    logic [PW-1:0]       out_delay_reg, out_delay_next;
    logic                out_err_reg, out_err_next;

    // combinational helpers
    logic [DVS_W:0]      shifted;
    logic                geq;
    logic [DVS_W:0]      trial;
    logic [2*DIV_W-1:0]  by_five;
    logic [TW-1:0]       tick_diff;
    logic [TW-1:0]       diff_end;
    logic [TW-1:0]       delta_v;
    logic [TW-1:0]       render;
    logic [AW-1:0]       active_v;
    logic [RW-1:0]       smooth_v;
    logic [RW-1:0]       target_fx;
    logic [RW-1:0]       mag;
    logic                above;
    logic                out_free;

    assign events.ready  = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign results.valid        = out_valid_reg;
    assign results.frame_delta  = out_delta_reg;
    assign results.delay_ticks  = out_delay_reg;
    assign results.config_error = out_err_reg;

    // divider step: one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign geq     = (shifted >= {1'b0, dvs_reg});
    assign trial   = shifted - {1'b0, dvs_reg};

    assign by_five = (2*DIV_W)'(quo_reg) * (2*DIV_W)'(RECIP_5);

    assign tick_diff = events.tick - last_tick_reg;
    assign diff_end  = tick_reg - last_tick_reg;
    assign delta_v   = tick_diff[TW-1] ? TW'(period_reg) : tick_diff;
    assign render    = (diff_end[TW-1] || (diff_end == '0)) ? TW'(1) : diff_end;
    assign active_v  = ((target_rate_reg == '0) || (target_rate_reg > 12'd1000))
                       ? UNLIMITED : target_rate_reg[AW-1:0];
    assign smooth_v  = quo_reg[RW-1:0];
    assign target_fx = RW'({active_reg, {FB{1'b0}}});
    assign above     = (smooth_v > target_fx);
    assign mag       = above ? (smooth_v - target_fx) : (target_fx - smooth_v);
    assign out_free  = !out_valid_reg || results.ready;

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg;
        target_rate_next = target_rate_reg;
        fallback_next    = fallback_reg;
        last_tick_next   = last_tick_reg;
        period_next      = period_reg;
        smooth_next      = smooth_reg;
        active_next      = active_reg;
        op_next          = op_reg;
        tick_next        = tick_reg;
        delta_next       = delta_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        dvs_next         = dvs_reg;
        res_delta_next   = res_delta_reg;
        res_delay_next   = res_delay_reg;
        res_err_next     = res_err_reg;
        out_delta_next   = out_delta_reg;
        out_delay_next   = out_delay_reg;
        out_err_next     = out_err_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg.valid)
        begin
            case (cfg.index)
                frp_pkg::REG_TARGET_RATE:     target_rate_next = cfg.data[11:0];
                frp_pkg::REG_FALLBACK_PERIOD: fallback_next    = cfg.data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (events.valid)
                begin
                    op_next        = events.operation;
                    tick_next      = events.tick;
                    res_delta_next = '0;
                    res_delay_next = '0;
                    res_err_next   = 1'b0;
                    rem_next       = '0;
                    cnt_next       = '0;
                    case (events.operation)
                        frp_pkg::OP_BEGIN:
                        begin
                            active_next    = active_v;
                            smooth_next    = RW'({active_v, {FB{1'b0}}});
                            last_tick_next = events.tick;
                            quo_next       = DIVIDEND_1K;
                            dvs_next       = DVS_W'(active_v);
                            phase_next     = PH_BEGIN;
                            state_next     = ST_DIV;
                        end
                        frp_pkg::OP_FRAME_START:
                        begin
                            delta_next = delta_v;
                            phase_next = PH_MEAS;
                            if (delta_v == '0)
                            begin
                                // zero delta reads as 1000 fps, no division
                                quo_next   = RATE_1000;
                                state_next = ST_POST;
                            end
                            else
                            begin
                                quo_next   = RATE_1000;
                                dvs_next   = delta_v;
                                state_next = ST_DIV;
                            end
                        end
                        frp_pkg::OP_FRAME_END:
                        begin
                            state_next = ST_END;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_DIV:
            begin
                rem_next = geq ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], geq};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    state_next = ST_POST;
                end
            end

            ST_SCALE:
            begin
                quo_next   = DIV_W'(by_five >> RECIP_SHIFT);
                state_next = ST_POST;
            end

            ST_POST:
            begin
                case (phase_reg)
                    PH_BEGIN:
                    begin
                        period_next  = quo_reg[PW-1:0];
                        res_err_next = (quo_reg[PW-1:0] > fallback_reg);
                        state_next   = ST_DONE;
                    end
                    PH_MEAS:
                    begin
                        // smoothed*0.2 + measured*0.8 = (s + 4m) / 5
                        quo_next   = DIV_W'(smooth_reg) + {quo_reg[DIV_W-3:0], 2'b00};
                        phase_next = PH_SMOOTH;
                        state_next = ST_SCALE;
                    end
                    PH_SMOOTH:
                    begin
                        smooth_next = smooth_v;
                        if (mag >= RW'(DEAD_BAND))
                        begin
                            if (above)
                            begin
                                if (period_reg != PERIOD_MAX)
                                    period_next = period_reg + PW'(1);
                            end
                            else if (period_reg > PW'(1))
                            begin
                                period_next = period_reg - PW'(1);
                            end
                        end
                        res_delta_next = (delta_reg > TW'(fallback_reg))
                                         ? fallback_reg : delta_reg[PW-1:0];
                        last_tick_next = tick_reg;
                        state_next     = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_END:
            begin
                if ((active_reg <= AW'(1000)) && (render < TW'(period_reg)))
                begin
                    res_delay_next = period_reg - render[PW-1:0];
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_delta_next = res_delta_reg;
                    out_delay_next = res_delay_reg;
                    out_err_next   = res_err_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_BEGIN;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            target_rate_reg <= 12'd60;
            fallback_reg    <= PW'(100);
            last_tick_reg   <= '0;
            period_reg      <= PW'(17);
            smooth_reg      <= RW'(60) << FB;
            active_reg      <= AW'(60);
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
            target_rate_reg <= target_rate_next;
            fallback_reg    <= fallback_next;
            last_tick_reg   <= last_tick_next;
            period_reg      <= period_next;
            smooth_reg      <= smooth_next;
            active_reg      <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        tick_reg      <= tick_next;
        delta_reg     <= delta_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dvs_reg       <= dvs_next;
        res_delta_reg <= res_delta_next;
        res_delay_reg <= res_delay_next;
        res_err_reg   <= res_err_next;
        out_delta_reg <= out_delta_next;
        out_delay_reg <= out_delay_next;
        out_err_reg   <= out_err_next;
    end

    // a taken request blocks the next one until its result is queued
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        events.valid && events.ready |=> !events.ready)
        else $error("request taken while another is in progress");

    // the smoothed rate never exceeds the unlimited target
    a_smooth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        smooth_reg <= RATE_MAX)
        else $error("smoothed rate out of range");

    // config error only comes from a begin
    a_err_from_begin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && res_err_reg |-> (op_reg == frp_pkg::OP_BEGIN))
        else $error("config error on non-begin request");

    // the divider never divides by zero
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (dvs_reg != '0))
        else $error("division by zero");

    // a new result is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !results.ready |=> out_valid_reg && $stable(out_delta_reg))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: dv/frame_rate_pacer_check.sv
// ----------------------------------------------------------------------------
// frame_rate_pacer_check: pacing predictor and result scoreboard
// Watches the event, result and register channels. It runs its own copy of
// the pacer state for every accepted request and compares each returned
// result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module frame_rate_pacer_check
    import frp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    frp_event_if   events,
    frp_result_if  results,
    frp_cfg_if     cfg,
    output int     mismatches,
    output int     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int            REPORT_LIMIT = 10;
    localparam int            UNLIMITED    = 2000;
    localparam logic [63:0]   RATE_ONE     = 64'd1 << RATE_FRAC_BITS;

    typedef struct packed {
        logic [PERIOD_W-1:0] frame_delta;
        logic [PERIOD_W-1:0] delay_ticks;
        logic                config_error;
    } pacer_result_t;

    logic [TICK_WIDTH-1:0] last_tick;
    logic [PERIOD_W-1:0]   period;
    logic [RATE_W-1:0]     smooth_rate;
    logic [ACTIVE_W-1:0]   active_target;
    logic [TARGET_W-1:0]   target_reg;
    logic [PERIOD_W-1:0]   fallback_reg;
    pacer_result_t         expected_results[$];

    // advances the pacer state by one event and returns its result
    function automatic pacer_result_t pace_event(op_t op, logic [TICK_WIDTH-1:0] stamp);
        pacer_result_t         r;
        logic [TICK_WIDTH-1:0] diff;
        logic [63:0]           delta;
        logic [63:0]           measured;
        logic [63:0]           smooth_next;
        logic [63:0]           target_fx;
        logic [63:0]           offset_fx;
        logic [63:0]           render;
        logic                  above;
        r = '0;
        diff = stamp - last_tick;
        case (op)
            OP_BEGIN:
            begin
                last_tick = stamp;
                if (target_reg == 0 || target_reg > 1000)
                    active_target = ACTIVE_W'(UNLIMITED);
                else
                    active_target = target_reg[ACTIVE_W-1:0];
                smooth_rate = RATE_W'(64'(active_target) * RATE_ONE);
                period = PERIOD_W'(1000 / active_target);
                r.config_error = period > fallback_reg;
            end
            OP_FRAME_START:
            begin
                // a tick stamp behind the last frame counts as one nominal period
                delta = diff[TICK_WIDTH-1] ? 64'(period) : 64'(diff);
                measured = (delta == 0) ? 64'd1000 * RATE_ONE : (64'd1000 * RATE_ONE) / delta;
                smooth_next = (64'(smooth_rate) + 64'd4 * measured) / 64'd5;
                smooth_rate = RATE_W'(smooth_next);
                target_fx = 64'(active_target) * RATE_ONE;
                above = smooth_next > target_fx;
                offset_fx = above ? smooth_next - target_fx : target_fx - smooth_next;
                // dead band of 0.0001 around the target
                if (offset_fx * 64'd10000 >= RATE_ONE)
                begin
                    if (above)
                    begin
                        if (period != '1)
                            period = period + 1'b1;
                    end
                    else if (period > 1)
                    begin
                        period = period - 1'b1;
                    end
                end
                r.frame_delta = (delta > 64'(fallback_reg)) ? fallback_reg : PERIOD_W'(delta);
                last_tick = stamp;
            end
            OP_FRAME_END:
            begin
                if (active_target <= 1000)
                begin
                    render = (diff[TICK_WIDTH-1] || diff == 0) ? 64'd1 : 64'(diff);
                    if (render < 64'(period))
                        r.delay_ticks = PERIOD_W'(64'(period) - render);
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(string field, logic [PERIOD_W-1:0] want,
                                 logic [PERIOD_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        pacer_result_t want;
        if (!rst_n)
        begin
            last_tick     = '0;
            period        = PERIOD_W'(17);
            smooth_rate   = RATE_W'(64'd60 * RATE_ONE);
            active_target = ACTIVE_W'(60);
            target_reg    = TARGET_W'(60);
            fallback_reg  = PERIOD_W'(100);
            expected_results.delete();
            mismatches    = 0;
            outstanding   = 0;
        end
        else
        begin
            // results first: one accepted at this edge cannot belong to a request
            // accepted at the same edge
            if (results.valid && results.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result with no request pending: delta %0d delay %0d err %0d",
                                 $realtime, results.frame_delta, results.delay_ticks,
                                 results.config_error);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("frame_delta", want.frame_delta, results.frame_delta);
                    compare_field("delay_ticks", want.delay_ticks, results.delay_ticks);
                    compare_field("config_error", PERIOD_W'(want.config_error),
                                  PERIOD_W'(results.config_error));
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_TARGET_RATE:     target_reg = cfg.data[TARGET_W-1:0];
                    REG_FALLBACK_PERIOD: fallback_reg = cfg.data;
                    default:
                    begin
                    end
                endcase
            end
            if (events.valid && events.ready)
                expected_results.push_back(pace_event(events.operation, events.tick));
            outstanding = expected_results.size();
        end
    end

endmodule

FILE: dv/frame_rate_pacer_tb.sv
// ----------------------------------------------------------------------------
// frame_rate_pacer_tb: testbench top for the frame rate pacer
// Drives directed and random begin / frame start / frame end / unused requests under
// a series of register settings, with random gaps on both channels and one
// long result back-pressure stretch. Checking is done by the scoreboard.
// ----------------------------------------------------------------------------
module frame_rate_pacer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frp_pkg::*;

    localparam op_t OP_UNUSED      = 2'd3;
    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  LONG_HOLD      = 400;
    localparam int  DRAIN_CYCLES   = 80;
    localparam int  PHASE_ITEMS    = 53;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   idle_cycles;
    int   hold_requests;
    bit   tx_steady;

    frp_event_if  events();
    frp_result_if results();
    frp_cfg_if    cfg();

    frame_rate_pacer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .events  (events),
        .results (results),
        .cfg     (cfg)
    );

    frame_rate_pacer_check pacing_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .events      (events),
        .results     (results),
        .cfg         (cfg),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #6 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    endfunction

    task automatic send_event(op_t op, logic [TICK_WIDTH-1:0] stamp);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_steady = !tx_steady;
        gap = (tx_steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0)
        begin
            events.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        events.valid     <= 1'b1;
        events.operation <= op;
        events.tick      <= stamp;
        do @(posedge clk); while (!events.ready);
    endtask

    // stop offering requests and wait for every result to come back
    task automatic settle();
        events.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        settle();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    task automatic set_pacing(logic [TARGET_W-1:0] target, logic [PERIOD_W-1:0] fallback);
        // upper data bits of the target write are don't-care
        write_reg(REG_TARGET_RATE, {4'($urandom_range(0, 15)), target});
        write_reg(REG_FALLBACK_PERIOD, fallback);
    endtask

    // mostly well-formed frame sequences around the nominal period, some noise
    task automatic run_phase(logic [TARGET_W-1:0] target, logic [PERIOD_W-1:0] fallback,
                             bit with_hold);
        int                    nominal;
        int                    roll;
        logic [TICK_WIDTH-1:0] now;
        set_pacing(target, fallback);
        nominal = (target == 0 || target > 1000) ? 1 : 1000 / target;
        now = $urandom();
        if ($urandom_range(0, 9) != 0)
            send_event(OP_BEGIN, now);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (with_hold && i == PHASE_ITEMS / 3)
                hold_requests++;
            roll = $urandom_range(0, 19);
            if (roll == 0)
                send_event(op_t'($urandom_range(0, 3)), $urandom());
            else if (roll == 1)
                send_event(op_t'($urandom_range(1, 2)), now - $urandom_range(1, 50));
            else if (roll == 2)
            begin
                now = now + $urandom_range(0, 20);
                send_event(OP_BEGIN, now);
            end
            else if (roll < 12)
            begin
                if ($urandom_range(0, 9) == 0)
                    now = now + $urandom_range(0, 70000);
                else
                    now = now + $urandom_range(0, 2 * nominal + 2);
                send_event(OP_FRAME_START, now);
            end
            else
                send_event(OP_FRAME_END, now + $urandom_range(0, nominal + 3));
        end
    endtask

    // result side: random stalls, quiet stretches, and the long hold on demand
    initial
    begin : result_sink
        int  stall;
        int  holds_served;
        bit  rx_steady;
        stall        = 0;
        holds_served = 0;
        rx_steady    = 1'b0;
        results.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 99) == 0)
                rx_steady = !rx_steady;
            if (holds_served != hold_requests)
            begin
                holds_served++;
                results.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                results.ready <= 1'b1;
            end
            else if (stall > 0)
            begin
                stall--;
                results.ready <= 1'b0;
            end
            else
            begin
                results.ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (events.valid && events.ready) || (results.valid && results.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("frame_rate_pacer_tb failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        hold_requests = 0;
        tx_steady     = 1'b0;
        idle_cycles   = 0;
        rst_n            <= 1'b0;
        events.valid     <= 1'b0;
        events.operation <= OP_BEGIN;
        events.tick      <= '0;
        cfg.valid        <= 1'b0;
        cfg.index        <= REG_TARGET_RATE;
        cfg.data         <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: target 60, fallback 100, period 17
        send_event(OP_FRAME_END, 32'd5);
        send_event(OP_FRAME_START, 32'd0);            // zero delta
        send_event(OP_FRAME_START, 32'hFFFF_FFF0);    // negative delta
        send_event(OP_UNUSED, 32'hFFFF_FFFF);
        send_event(OP_FRAME_END, 32'h0000_0000);      // render across the wrap
        send_event(OP_FRAME_END, 32'hFFFF_FFF0);      // zero render
        send_event(OP_FRAME_END, 32'hFFFF_FFE0);      // negative render
        send_event(OP_BEGIN, 32'h8000_0000);
        send_event(OP_FRAME_START, 32'h8000_00C8);    // clamped to fallback

        // period floor of 1, exact rate inside the dead band, period above fallback
        set_pacing(12'd1000, 16'd0);
        send_event(OP_BEGIN, 32'd0);
        send_event(OP_FRAME_START, 32'd1);
        send_event(OP_FRAME_START, 32'd11);
        send_event(OP_FRAME_END, 32'd11);

        set_pacing(12'd100, 16'hFFFF);
        send_event(OP_BEGIN, 32'd1000);
        send_event(OP_FRAME_START, 32'd1010);
        send_event(OP_FRAME_START, 32'd1015);
        send_event(OP_FRAME_END, 32'd1018);
        send_event(OP_FRAME_END, 32'd1055);

        // unlimited target
        set_pacing(12'd0, 16'hFFFF);
        send_event(OP_BEGIN, 32'd7);
        send_event(OP_FRAME_START, 32'd8);
        send_event(OP_FRAME_END, 32'd9);

        set_pacing(12'd1, 16'd999);
        send_event(OP_BEGIN, 32'd100);
        send_event(OP_FRAME_START, 32'd100 + 32'h7FFF_FFFF);
        send_event(OP_FRAME_END, 32'd100 + 32'h7FFF_FFFF + 32'd3);

        run_phase(12'd60, 16'd100, 1'b0);
        run_phase(12'd1, 16'd0, 1'b1);
        run_phase(12'd4095, 16'hFFFF, 1'b0);
        run_phase(12'd1000, 16'd1, 1'b0);
        run_phase(12'd1001, 16'd500, 1'b0);
        run_phase(12'd0, 16'd0, 1'b0);
        run_phase(12'd30, 16'd20, 1'b0);
        run_phase(12'($urandom_range(1, 200)), 16'($urandom_range(0, 65535)), 1'b0);
        run_phase(12'($urandom_range(1, 1000)), 16'($urandom_range(0, 300)), 1'b0);
        run_phase(12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)), 1'b0);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("frame_rate_pacer_tb passed");
        else
            $display("frame_rate_pacer_tb failed");
        $finish;
    end

endmodule
